// ----- src/stride_scheduler_with_reservations_assert.svh -----
// Assertion macros shared by the stride scheduler RTL.
`ifndef STRIDE_SCHEDULER_WITH_RESERVATIONS_ASSERT_SVH
`define STRIDE_SCHEDULER_WITH_RESERVATIONS_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SSR_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ssr same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SSR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ssr next-cycle check failed");

`endif

// ----- src/ssr_pkg.sv -----
// Types and constants of the stride scheduler.
package ssr_pkg;

    // Command carried by an input word.
    typedef enum logic [1:0] {
        KIND_START    = 2'd0,
        KIND_END      = 2'd1,
        KIND_REQUEST  = 2'd2,
        KIND_SCHEDULE = 2'd3
    } kind_t;

    // Status returned in a result word.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_REJECTED  = 3'd3,
        ST_NONE      = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_FREE,
        S_FIND_RD,
        S_FIND_CHK,
        S_ACT,
        S_REQ_DIV,
        S_REQ_WAIT,
        S_SHR,
        S_SHR_WAIT,
        S_STR,
        S_STR_WAIT,
        S_REB_RD,
        S_REB_WR,
        S_SCH_RD,
        S_SCH_CHK,
        S_SCH_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] proc_id;
        logic [6:0]  percent;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] chosen_id;
    } result_t;

    // One row of the process table as stored in the RAM.
    typedef struct packed {
        logic [15:0] id;
        logic        reserved;
        logic [9:0]  share;
        logic [16:0] stride;
        logic [31:0] pass;
        logic        halted;
    } entry_t;

    localparam int DIV_W = 17;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_res_t;

    localparam logic [DIV_W-1:0] FULL_SCALE   = 17'd100000;
    localparam logic [10:0]      BUDGET_TOTAL = 11'd1000;
    localparam logic [10:0]      BUDGET_MAX   = 11'd2047;
    localparam logic [8:0]       COUNT_MAX    = 9'd511;
    localparam logic [6:0]       PERCENT_MAX  = 7'd100;

endpackage

// ----- src/stride_scheduler_with_reservations.sv -----
// Top level of the stride scheduler: sequencer, table RAM and divider.
//
//  Channel  | Signals                            | Word
//  ---------+------------------------------------+-----------------------------
//  item     | item_valid, item_stall, item       | kind, proc_id, percent
//  result   | result_valid, result_stall, result | status, chosen_id
//
// One word is handled at a time. How long a word takes is set by the table
// walks through the single RAM read port and by up to three divider passes
// (17 quotient bits each, then the done pulse).
// Reset clears the valid bits and count and sets the budget to BUDGET_TOTAL at once; no clearing pass.
// A finished result sits in an output register; the next word is taken while
// it waits, and the sequencer holds before writing over it.
`include "stride_scheduler_with_reservations_assert.svh"

module stride_scheduler_with_reservations #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ssr_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output ssr_pkg::result_t result
);
    import ssr_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(MAX_ENTRIES - 1);

    // Control state.
    state_t                 state_reg, state_next;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [10:0]            budget_reg;
    logic [8:0]             count_reg;
    logic                   result_valid_reg;

    // Working registers.
    kind_t                  kind_reg;
    logic [15:0]            id_reg;
    logic [6:0]             pct_reg;
    status_t                status_reg;
    logic [15:0]            chosen_reg;
    logic [IW-1:0]          idx_reg;
    logic [IW-1:0]          hit_idx_reg;
    entry_t                 hit_word_reg;
    logic [IW-1:0]          best_idx_reg;
    entry_t                 best_word_reg;
    logic                   found_reg;
    logic [10:0]            share_reg;
    logic [16:0]            stride_reg;
    logic                   halt_reg;
    result_t                result_reg;

    // RAM and divider connections.
    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    entry_t                 ram_wdata;
    entry_t                 rd;
    div_req_t               div_req;
    div_res_t               div_res;

    // Shared helper values.
    logic                   last;
    logic                   hit;
    logic                   cand;
    logic                   take;
    logic [10:0]            want;
    logic [11:0]            avail;
    logic [11:0]            remain;
    logic                   over;
    logic [10:0]            budget_back;
    logic [11:0]            back_sum;
    logic [32:0]            pass_sum;
    logic                   can_load;

    ssr_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (rd)
    );

    ssr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    // Compares and budget arithmetic used by the sequencer.
    always_comb
    begin
        last        = (idx_reg == LAST);
        hit         = valid_reg[idx_reg] && (rd.id == id_reg);
        cand        = valid_reg[idx_reg] && !rd.halted;
        take        = cand && (!found_reg || (rd.pass < best_word_reg.pass));
        want        = ({4'b0, pct_reg} << 3) + ({4'b0, pct_reg} << 1);
        avail       = {1'b0, budget_reg} + {2'b0, hit_word_reg.share};
        remain      = avail - {1'b0, want};
        over        = ({1'b0, want} > avail);
        back_sum    = avail;
        budget_back = (back_sum > {1'b0, BUDGET_MAX}) ? BUDGET_MAX : back_sum[10:0];
        pass_sum    = {1'b0, best_word_reg.pass} + {16'b0, best_word_reg.stride};
        can_load    = !result_valid_reg || !result_stall;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (kind_t'(item.kind))
                        KIND_START:    state_next = S_FREE;
                        KIND_END:      state_next = S_FIND_RD;
                        KIND_REQUEST:  state_next = (item.percent > PERCENT_MAX) ?
                                                    S_DONE : S_FIND_RD;
                        KIND_SCHEDULE: state_next = S_SCH_RD;
                        default:       state_next = S_DONE;
                    endcase
                end
            end
            S_FREE:
            begin
                priority if (!valid_reg[idx_reg]) state_next = S_SHR;
                else if (last)                    state_next = S_DONE;
            end
            S_FIND_RD:  state_next = S_FIND_CHK;
            S_FIND_CHK:
            begin
                priority if (hit) state_next = S_ACT;
                else if (last)    state_next = S_DONE;
                else              state_next = S_FIND_RD;
            end
            S_ACT:
            begin
                priority if (kind_reg == KIND_END) state_next = S_SHR;
                else if (want == '0)               state_next = S_SHR;
                else if (over)                     state_next = S_DONE;
                else                               state_next = S_REQ_DIV;
            end
            S_REQ_DIV:  state_next = S_REQ_WAIT;
            S_REQ_WAIT: state_next = div_res.done ? S_SHR : S_REQ_WAIT;
            S_SHR:      state_next = (count_reg == '0) ? S_STR : S_SHR_WAIT;
            S_SHR_WAIT: state_next = div_res.done ? S_STR : S_SHR_WAIT;
            S_STR:      state_next = (share_reg == '0) ? S_REB_RD : S_STR_WAIT;
            S_STR_WAIT: state_next = div_res.done ? S_REB_RD : S_STR_WAIT;
            S_REB_RD:   state_next = S_REB_WR;
            S_REB_WR:   state_next = last ? S_DONE : S_REB_RD;
            S_SCH_RD:   state_next = S_SCH_CHK;
            S_SCH_CHK:
            begin
                if (last)
                begin
                    state_next = (found_reg || take) ? S_SCH_WR : S_DONE;
                end
                else
                begin
                    state_next = S_SCH_RD;
                end
            end
            S_SCH_WR:   state_next = S_DONE;
            S_DONE:     state_next = can_load ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Output logic: RAM writes, divider starts and the input stall.
    always_comb
    begin
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_wdata        = hit_word_reg;
        div_req.start    = 1'b0;
        div_req.dividend = FULL_SCALE;
        div_req.divisor  = {6'b0, want};
        item_stall       = (state_reg != S_IDLE);
        unique case (state_reg)
            S_FREE:
            begin
                ram_we       = !valid_reg[idx_reg];
                ram_wdata    = '0;
                ram_wdata.id = id_reg;
            end
            S_ACT:
            begin
                ram_waddr          = hit_idx_reg;
                ram_we             = (kind_reg == KIND_REQUEST) && (want == '0) &&
                                     hit_word_reg.reserved;
                ram_wdata.reserved = 1'b0;
                ram_wdata.share    = '0;
            end
            S_REQ_DIV:
            begin
                div_req.start = 1'b1;
            end
            S_REQ_WAIT:
            begin
                ram_waddr          = hit_idx_reg;
                ram_we             = div_res.done;
                ram_wdata.reserved = 1'b1;
                ram_wdata.share    = want[9:0];
                ram_wdata.stride   = div_res.quotient;
                ram_wdata.halted   = 1'b0;
            end
            S_SHR:
            begin
                div_req.start    = (count_reg != '0);
                div_req.dividend = {6'b0, budget_reg};
                div_req.divisor  = {8'b0, count_reg};
            end
            S_STR:
            begin
                div_req.start   = (share_reg != '0);
                div_req.divisor = {6'b0, share_reg};
            end
            S_REB_WR:
            begin
                ram_we    = valid_reg[idx_reg];
                ram_wdata = rd;
                if (!rd.reserved)
                begin
                    ram_wdata.stride = stride_reg;
                    ram_wdata.halted = halt_reg;
                end
                ram_wdata.pass = '0;
            end
            S_SCH_WR:
            begin
                ram_we         = 1'b1;
                ram_waddr      = best_idx_reg;
                ram_wdata      = best_word_reg;
                ram_wdata.pass = pass_sum[32] ? '1 : pass_sum[31:0];
            end
            default:
            begin
            end
        endcase
    end

    // State register, table flags, budget, count and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            valid_reg        <= '0;
            budget_reg       <= BUDGET_TOTAL;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_FREE:
                begin
                    if (!valid_reg[idx_reg])
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        if (count_reg != COUNT_MAX)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                S_ACT:
                begin
                    if (kind_reg == KIND_END)
                    begin
                        valid_reg[hit_idx_reg] <= 1'b0;
                        if (hit_word_reg.reserved)
                        begin
                            budget_reg <= budget_back;
                        end
                        else if (count_reg != '0)
                        begin
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                    else if (want != '0)
                    begin
                        if (!over)
                        begin
                            budget_reg <= (remain > {1'b0, BUDGET_MAX}) ?
                                          BUDGET_MAX : remain[10:0];
                            if (!hit_word_reg.reserved && (count_reg != '0))
                            begin
                                count_reg <= count_reg - 1'b1;
                            end
                        end
                    end
                    else if (hit_word_reg.reserved)
                    begin
                        budget_reg <= budget_back;
                        if (count_reg != COUNT_MAX)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (can_load)
                    begin
                        result_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if ((state_reg != S_DONE) && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the table walk and the result register.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    kind_reg   <= kind_t'(item.kind);
                    id_reg     <= item.proc_id;
                    pct_reg    <= item.percent;
                    idx_reg    <= '0;
                    found_reg  <= 1'b0;
                    chosen_reg <= '0;
                    status_reg <= ((kind_t'(item.kind) == KIND_REQUEST) &&
                                   (item.percent > PERCENT_MAX)) ? ST_REJECTED : ST_OK;
                end
            end
            S_FREE:
            begin
                if (valid_reg[idx_reg])
                begin
                    if (last)
                    begin
                        status_reg <= ST_FULL;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
            end
            S_FIND_CHK:
            begin
                priority if (hit)
                begin
                    hit_idx_reg  <= idx_reg;
                    hit_word_reg <= rd;
                end
                else if (last)
                begin
                    status_reg <= ST_NOT_FOUND;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            S_ACT:
            begin
                if ((kind_reg == KIND_REQUEST) && (want != '0) && over)
                begin
                    status_reg <= ST_REJECTED;
                end
            end
            S_SHR:
            begin
                if (count_reg == '0)
                begin
                    share_reg <= '0;
                end
            end
            S_SHR_WAIT:
            begin
                if (div_res.done)
                begin
                    share_reg <= div_res.quotient[10:0];
                end
            end
            S_STR:
            begin
                idx_reg <= '0;
                if (share_reg == '0)
                begin
                    stride_reg <= '0;
                    halt_reg   <= 1'b1;
                end
                else
                begin
                    halt_reg <= 1'b0;
                end
            end
            S_STR_WAIT:
            begin
                if (div_res.done)
                begin
                    stride_reg <= div_res.quotient;
                end
            end
            S_REB_WR:
            begin
                if (!last)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            S_SCH_CHK:
            begin
                if (take)
                begin
                    found_reg     <= 1'b1;
                    best_idx_reg  <= idx_reg;
                    best_word_reg <= rd;
                end
                if (last)
                begin
                    if (!(found_reg || take))
                    begin
                        status_reg <= ST_NONE;
                    end
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            S_SCH_WR:
            begin
                chosen_reg <= best_word_reg.id;
            end
            S_DONE:
            begin
                if (can_load)
                begin
                    result_reg.status    <= status_reg;
                    result_reg.chosen_id <= chosen_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The unreserved count never exceeds the number of live entries.
    `SSR_ASSERT_NOW(a_count_le_valid, clk, rst_n, 1'b1,
                    ({23'b0, count_reg} <= $countones(valid_reg)))
    // A finished word reaches the output register and the sequencer goes idle.
    `SSR_ASSERT_NEXT(a_done_loads, clk, rst_n, (state_reg == S_DONE) && can_load,
                     result_valid_reg && (state_reg == S_IDLE))
    // The pass update only happens after a runnable entry was found.
    `SSR_ASSERT_NOW(a_sched_found, clk, rst_n, state_reg == S_SCH_WR, found_reg)
    // A divider result only arrives while the sequencer waits for one.
    `SSR_ASSERT_NOW(a_div_expected, clk, rst_n, div_res.done,
                    (state_reg == S_REQ_WAIT) || (state_reg == S_SHR_WAIT) ||
                    (state_reg == S_STR_WAIT))

endmodule

// ----- src/ssr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ssr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/ssr_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module ssr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ssr_pkg::div_req_t req,
    output ssr_pkg::div_res_t res
);
    import ssr_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = !diff[DIV_W];
    end

    // Control: busy while bits remain, done pulses after the last bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift together.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

// ----- tb/sv/stride_scheduler_with_reservations_tb.sv -----
// Self-checking testbench for the stride scheduler with reservations.
`timescale 1ns / 1ps

module stride_scheduler_with_reservations_tb;
    import ssr_pkg::*;

    localparam int N = 16;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    // Scheduler state as predicted by the testbench.
    logic        tab_valid [N];
    logic [15:0] tab_id [N];
    logic        tab_rsv [N];
    logic [10:0] tab_share [N];
    logic [16:0] tab_stride [N];
    logic [31:0] tab_pass [N];
    logic        tab_halt [N];
    logic [10:0] budget_left;
    logic [8:0]  shared_count;

    result_t answer_q[$];
    int      errors;
    int      words_sent;
    int      words_checked;
    int      picks_seen;
    bit      hold_results;
    bit      wild_stall;

    stride_scheduler_with_reservations #(.MAX_ENTRIES(N)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

    // Recompute strides of unreserved entries and clear the pass value of every live entry.
    function automatic void rebalance_table();
        logic [10:0] each;
        each = (shared_count != 0) ? budget_left / shared_count : 11'd0;
        for (int k = 0; k < N; k++)
        begin
            if (tab_valid[k])
            begin
                if (!tab_rsv[k])
                begin
                    tab_stride[k] = (each != 0) ? 17'(100000 / each) : 17'd0;
                    tab_halt[k] = (each == 0);
                end
                tab_pass[k] = 32'd0;
            end
        end
    endfunction

    function automatic int lookup_id(logic [15:0] id);
        for (int k = 0; k < N; k++)
            if (tab_valid[k] && tab_id[k] == id)
                return k;
        return -1;
    endfunction

    function automatic void drop_entry(int k);
        tab_valid[k] = 0;
        tab_id[k] = 0;
        tab_rsv[k] = 0;
        tab_share[k] = 0;
        tab_stride[k] = 0;
        tab_pass[k] = 0;
        tab_halt[k] = 0;
    endfunction

    function automatic void reset_table();
        for (int k = 0; k < N; k++)
            drop_entry(k);
        budget_left = 11'd1000;
        shared_count = 0;
    endfunction

    function automatic void raise_budget(logic [10:0] v);
        int s;
        s = budget_left + v;
        budget_left = (s > 2047) ? 11'd2047 : 11'(s);
    endfunction

    // Apply one command to the predicted table and return its answer.
    function automatic result_t apply_command(item_t w);
        result_t r;
        int k;
        int want;
        int avail;
        int sum;
        r.status = ST_OK;
        r.chosen_id = 16'd0;
        case (kind_t'(w.kind))
            KIND_START:
            begin
                k = -1;
                for (int j = 0; j < N; j++)
                    if (k < 0 && !tab_valid[j])
                        k = j;
                if (k < 0)
                    r.status = ST_FULL;
                else
                begin
                    drop_entry(k);
                    tab_valid[k] = 1;
                    tab_id[k] = w.proc_id;
                    if (shared_count < 511)
                        shared_count++;
                    rebalance_table();
                end
            end
            KIND_END:
            begin
                k = lookup_id(w.proc_id);
                if (k < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    if (tab_rsv[k])
                        raise_budget(tab_share[k]);
                    else if (shared_count > 0)
                        shared_count--;
                    drop_entry(k);
                    rebalance_table();
                end
            end
            KIND_REQUEST:
            begin
                k = lookup_id(w.proc_id);
                want = w.percent * 10;
                if (w.percent > 100)
                    r.status = ST_REJECTED;
                else if (k < 0)
                    r.status = ST_NOT_FOUND;
                else if (want != 0 && want > budget_left + tab_share[k])
                    r.status = ST_REJECTED;
                else
                begin
                    if (want != 0)
                    begin
                        avail = budget_left + tab_share[k] - want;
                        budget_left = (avail > 2047) ? 11'd2047 : 11'(avail);
                        if (!tab_rsv[k] && shared_count > 0)
                            shared_count--;
                        tab_rsv[k] = 1;
                        tab_share[k] = 11'(want);
                        tab_stride[k] = 17'(100000 / want);
                        tab_halt[k] = 0;
                    end
                    else if (tab_rsv[k])
                    begin
                        raise_budget(tab_share[k]);
                        tab_share[k] = 0;
                        tab_rsv[k] = 0;
                        if (shared_count < 511)
                            shared_count++;
                    end
                    rebalance_table();
                end
            end
            default:
            begin
                k = -1;
                for (int j = 0; j < N; j++)
                    if (tab_valid[j] && !tab_halt[j])
                        if (k < 0 || tab_pass[j] < tab_pass[k])
                            k = j;
                if (k < 0)
                    r.status = ST_NONE;
                else
                begin
                    sum = tab_pass[k] + tab_stride[k];
                    tab_pass[k] = (sum < tab_pass[k]) ? 32'hFFFF_FFFF : 32'(sum);
                    r.chosen_id = tab_id[k];
                end
            end
        endcase
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one word and record its expected answer once it is accepted.
    // Valid stays high after acceptance so that words can follow back to back;
    // a gap or the drain task takes it low.
    task automatic send_word(kind_t k, logic [15:0] id, logic [6:0] pct);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{kind: k, proc_id: id, percent: pct};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        answer_q.push_back(apply_command('{kind: k, proc_id: id, percent: pct}));
        words_sent++;
    endtask

    // Receiver back-pressure: random stalls, or a long hold when asked.
    initial
    begin
        int n;
        result_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                result_stall <= 1'b1;
                for (n = 0; n < 400; n++)
                    @(posedge clk);
                hold_results = 0;
                result_stall <= 1'b0;
            end
            else if (wild_stall)
                result_stall <= ($urandom_range(0, 99) < 30);
            else
                result_stall <= 1'b0;
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (answer_q.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d id=%0d", $time,
                    result.status, result.chosen_id);
                errors++;
            end
            else
            begin
                result_t e;
                e = answer_q.pop_front();
                words_checked++;
                if (e.status == ST_OK && e.chosen_id != 0)
                    picks_seen++;
                if (result.status != e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                        e.status, result.status);
                    errors++;
                end
                if (result.chosen_id != e.chosen_id)
                begin
                    $display("%0t: chosen_id expected %0d actual %0d", $time,
                        e.chosen_id, result.chosen_id);
                    errors++;
                end
            end
        end
    end

    // Stop offering words and wait until every expected result has arrived.
    task automatic drain();
        item_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
    endtask

    // Extremes of every field and the named corner cases.
    task automatic test_directed();
        send_word(KIND_SCHEDULE, 16'd0, 7'd0);
        send_word(KIND_END, 16'hFFFF, 7'd0);
        send_word(KIND_REQUEST, 16'd5, 7'd127);
        send_word(KIND_START, 16'hFFFF, 7'h7F);
        send_word(KIND_START, 16'd0, 7'd0);
        send_word(KIND_START, 16'hFFFF, 7'd0);
        send_word(KIND_REQUEST, 16'hFFFF, 7'd100);
        send_word(KIND_SCHEDULE, 16'd0, 7'd0);
        send_word(KIND_REQUEST, 16'd0, 7'd1);
        send_word(KIND_REQUEST, 16'd0, 7'd0);
        send_word(KIND_REQUEST, 16'hFFFF, 7'd0);
        send_word(KIND_REQUEST, 16'd0, 7'd101);
        send_word(KIND_REQUEST, 16'd0, 7'd60);
        send_word(KIND_REQUEST, 16'hFFFF, 7'd40);
        for (int i = 0; i < 4; i++)
            send_word(KIND_SCHEDULE, 16'hAAAA, 7'd0);
        send_word(KIND_END, 16'hFFFF, 7'd0);
        send_word(KIND_END, 16'd0, 7'd0);
        send_word(KIND_END, 16'hFFFF, 7'd0);
        drain();
    endtask

    // Fill the table past its size and schedule many times.
    task automatic test_full_table();
        for (int i = 0; i < N + 2; i++)
            send_word(KIND_START, 16'(i + 1), 7'($urandom));
        for (int i = 0; i < 40; i++)
            send_word(KIND_SCHEDULE, 16'($urandom), 7'($urandom));
        for (int i = 0; i < N; i++)
            send_word(KIND_END, 16'(i + 1), 7'd0);
        drain();
    endtask

    // Hold the result side while words keep coming, so the block backs up.
    task automatic test_backpressure();
        hold_results = 1;
        for (int i = 0; i < 8; i++)
            send_word(i < 3 ? KIND_START : KIND_SCHEDULE, 16'(i + 100), 7'd0);
        drain();
        for (int i = 0; i < 3; i++)
            send_word(KIND_END, 16'(i + 100), 7'd0);
        drain();
    endtask

    // Mostly meaningful commands on a small id pool, plus random noise.
    task automatic test_random(int count);
        int p;
        logic [15:0] id;
        logic [6:0] pct;
        wild_stall = 1;
        for (int i = 0; i < count; i++)
        begin
            p = $urandom_range(0, 99);
            id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 20));
            pct = ($urandom_range(0, 9) == 0) ? 7'($urandom) :
                7'($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 40));
            if (p < 22)
                send_word(KIND_START, id, 7'($urandom));
            else if (p < 38)
                send_word(KIND_END, id, 7'($urandom));
            else if (p < 55)
                send_word(KIND_REQUEST, id, pct);
            else
                send_word(KIND_SCHEDULE, 16'($urandom), 7'($urandom));
        end
        drain();
        wild_stall = 0;
    endtask

    initial
    begin
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        picks_seen = 0;
        hold_results = 0;
        wild_stall = 0;
        item_valid = 1'b0;
        item = '0;
        rst_n = 1'b0;
        reset_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_backpressure();
        test_random(600);
        repeat (200) @(posedge clk);
        $display("Sent %0d words, checked %0d results, %0d scheduling picks.",
            words_sent, words_checked, picks_seen);
        $display("Covered full table, reservations, budget exhaustion and a long stall.");
        if (errors == 0 && answer_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+src
src/ssr_pkg.sv
src/ssr_ram.sv
src/ssr_div.sv
src/stride_scheduler_with_reservations.sv
tb/sv/stride_scheduler_with_reservations_tb.sv
